>>> rtl/core/hsv2rgb_pkg.sv
// shared types and constants for the hsv to rgb pixel converter
`default_nettype none

package hsv2rgb_pkg;

    // input word: one hsv pixel with alpha
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] alpha_in;
    } hsv_word_t;

    // output word: one rgba pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } rgb_word_t;

    // hue sectors, named by the colors they run between
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    localparam logic [7:0]  SECTOR_STEPS = 8'd43;
    localparam logic [7:0]  FULL_SCALE   = 8'd255;
    // 255 * 43, the denominator of the middle level
    localparam logic [13:0] MID_DENOM    = 14'd10965;
    // floor(2^36 / 10965): quotient estimate is low by at most one
    localparam logic [22:0] MID_RECIP    = 23'd6267166;

endpackage

`default_nettype wire

>>> rtl/core/hsv_to_rgb_8bit_unit.sv
// hsv to rgba pixel converter, four-stage pipeline
//
// Usage:
//   hsv channel: hsv_valid / hsv_stall / hsv carry one hsv pixel word with
//   alpha. A word is taken at a rising edge with hsv_valid high and
//   hsv_stall low.
//   rgb channel: rgb_valid / rgb_stall / rgb carry one rgba pixel word out,
//   taken at a rising edge with rgb_valid high and rgb_stall low.
//   rgb_valid rises once the word reaches the stage d output register.
//   Throughput is one word per cycle while rgb_stall is low; the four
//   register stages (sector and products, middle product and divide by
//   255, reciprocal multiply, quotient correction and channel select)
//   each hold one word, the reciprocal multiply in stage three sets the
//   clock.
//   Reset clears all stage valid bits; the pipe comes up empty and ready.
//   When the receiver stalls, the output word holds and each stage keeps its
//   word while the stage after it is full; empty stages still fill, so up to
//   four words are held before hsv_stall rises. Nothing is dropped or
//   repeated.
`default_nettype none

module hsv_to_rgb_8bit_unit
    import hsv2rgb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      hsv_valid,
    output logic           hsv_stall,
    input  wire hsv_word_t hsv,
    output logic           rgb_valid,
    input  wire logic      rgb_stall,
    output rgb_word_t      rgb
);

    // stage valid bits
    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic ready_a, ready_b, ready_c, ready_d;

    // stage a payload
    sector_t     sector_a_reg;
    logic [7:0]  v_a_reg, alpha_a_reg;
    logic [13:0] sd_a_reg;
    logic [15:0] bprod_a_reg;

    // stage b payload
    sector_t     sector_b_reg;
    logic [7:0]  v_b_reg, alpha_b_reg, bot_b_reg;
    logic [21:0] mprod_b_reg;

    // stage c payload
    sector_t     sector_c_reg;
    logic [7:0]  v_c_reg, alpha_c_reg, bot_c_reg, q0_c_reg;
    logic [21:0] mprod_c_reg;

    // stage d (output) payload
    rgb_word_t   rgb_reg;

    // stage a next values
    sector_t     sector_next;
    logic [6:0]  pos_next;
    logic [5:0]  d_next;
    logic [13:0] sd_next;
    logic [15:0] bprod_next;

    // stage b next values
    logic [13:0] inner_next;
    logic [21:0] mprod_next;
    logic [15:0] bsum_next;
    logic [7:0]  bot_next;

    // stage c next values
    logic [44:0] recip_prod_next;
    logic [7:0]  q0_next;

    // stage d next values
    logic [21:0] qden_next;
    logic [21:0] rem_next;
    logic [8:0]  mid_wide_next;
    logic [7:0]  mid_next;
    rgb_word_t   rgb_next;

    // backpressure chain, a stage moves when it is empty or its word leaves
    assign ready_d   = !valid_d_reg || !rgb_stall;
    assign ready_c   = !valid_c_reg || ready_d;
    assign ready_b   = !valid_b_reg || ready_c;
    assign ready_a   = !valid_a_reg || ready_b;
    assign hsv_stall = !ready_a;

    // sector from hue compares
    always_comb
    begin
        if (hsv.hue >= 8'd215)
            sector_next = SEC_MAG_RED;
        else if (hsv.hue >= 8'd172)
            sector_next = SEC_BLU_MAG;
        else if (hsv.hue >= 8'd129)
            sector_next = SEC_CYN_BLU;
        else if (hsv.hue >= 8'd86)
            sector_next = SEC_GRN_CYN;
        else if (hsv.hue >= SECTOR_STEPS)
            sector_next = SEC_YEL_GRN;
        else
            sector_next = SEC_RED_YEL;
    end

    // distance of hue from the middle of its double sector
    always_comb
    begin
        if (hsv.hue >= 8'd172)
            pos_next = 7'(hsv.hue - 8'd172);
        else if (hsv.hue >= 8'd86)
            pos_next = 7'(hsv.hue - 8'd86);
        else
            pos_next = hsv.hue[6:0];
        if (pos_next >= 7'(SECTOR_STEPS))
            d_next = 6'(pos_next - 7'(SECTOR_STEPS));
        else
            d_next = 6'(7'(SECTOR_STEPS) - pos_next);
    end

    assign sd_next    = 14'(hsv.saturation) * 14'(d_next);
    assign bprod_next = 16'(hsv.brightness) * 16'(FULL_SCALE - hsv.saturation);

    // stage a registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (ready_a)
            valid_a_reg <= hsv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && hsv_valid)
        begin
            sector_a_reg <= sector_next;
            v_a_reg      <= hsv.brightness;
            alpha_a_reg  <= hsv.alpha_in;
            sd_a_reg     <= sd_next;
            bprod_a_reg  <= bprod_next;
        end
    end

    // middle level numerator and bottom level, x / 255 = (x + x/256 + 1) / 256
    assign inner_next = MID_DENOM - sd_a_reg;
    assign mprod_next = 22'(v_a_reg) * 22'(inner_next);
    assign bsum_next  = bprod_a_reg + 16'(bprod_a_reg[15:8]) + 16'd1;
    assign bot_next   = bsum_next[15:8];

    // stage b registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (ready_b)
            valid_b_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && valid_a_reg)
        begin
            sector_b_reg <= sector_a_reg;
            v_b_reg      <= v_a_reg;
            alpha_b_reg  <= alpha_a_reg;
            bot_b_reg    <= bot_next;
            mprod_b_reg  <= mprod_next;
        end
    end

    // quotient estimate by reciprocal multiply
    assign recip_prod_next = 45'(mprod_b_reg) * 45'(MID_RECIP);
    assign q0_next         = recip_prod_next[43:36];

    // stage c registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_c_reg <= 1'b0;
        else if (ready_c)
            valid_c_reg <= valid_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && valid_b_reg)
        begin
            sector_c_reg <= sector_b_reg;
            v_c_reg      <= v_b_reg;
            alpha_c_reg  <= alpha_b_reg;
            bot_c_reg    <= bot_b_reg;
            q0_c_reg     <= q0_next;
            mprod_c_reg  <= mprod_b_reg;
        end
    end

    // one-step quotient correction
    assign qden_next     = 22'(q0_c_reg) * 22'(MID_DENOM);
    assign rem_next      = mprod_c_reg - qden_next;
    assign mid_wide_next = 9'(q0_c_reg) + 9'(rem_next >= 22'(MID_DENOM));
    assign mid_next      = mid_wide_next[7:0];

    // channel select by sector
    always_comb
    begin
        rgb_next.alpha_out = alpha_c_reg;
        case (sector_c_reg)
            SEC_RED_YEL:
            begin
                rgb_next.red   = v_c_reg;
                rgb_next.green = mid_next;
                rgb_next.blue  = bot_c_reg;
            end
            SEC_YEL_GRN:
            begin
                rgb_next.red   = mid_next;
                rgb_next.green = v_c_reg;
                rgb_next.blue  = bot_c_reg;
            end
            SEC_GRN_CYN:
            begin
                rgb_next.red   = bot_c_reg;
                rgb_next.green = v_c_reg;
                rgb_next.blue  = mid_next;
            end
            SEC_CYN_BLU:
            begin
                rgb_next.red   = bot_c_reg;
                rgb_next.green = mid_next;
                rgb_next.blue  = v_c_reg;
            end
            SEC_BLU_MAG:
            begin
                rgb_next.red   = mid_next;
                rgb_next.green = bot_c_reg;
                rgb_next.blue  = v_c_reg;
            end
            default:
            begin
                rgb_next.red   = v_c_reg;
                rgb_next.green = bot_c_reg;
                rgb_next.blue  = mid_next;
            end
        endcase
    end

    // stage d registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_d_reg <= 1'b0;
        else if (ready_d)
            valid_d_reg <= valid_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_d && valid_c_reg)
            rgb_reg <= rgb_next;
    end

    assign rgb_valid = valid_d_reg;
    assign rgb       = rgb_reg;

    // reciprocal estimate is never more than one low
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg |-> (rem_next < 22'(2 * 10965)))
        else $error("middle level quotient estimate off by more than one");

    // bottom level never exceeds the top level
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg |-> (bot_c_reg <= v_c_reg))
        else $error("bottom level above top level");

    // middle level never exceeds the top level
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg |-> (mid_wide_next <= 9'(v_c_reg)))
        else $error("middle level above top level");

endmodule

`default_nettype wire

>>> dv/hsv_to_rgb_8bit_unit_tb.sv
// self-checking testbench for the hsv to rgba pixel converter
`timescale 1ns / 1ps

module hsv_to_rgb_8bit_unit_tb
    import hsv2rgb_pkg::*;
;

    localparam int DIR_COUNT     = 23;
    localparam int RANDOM_COUNT  = 1800;
    localparam int QUIET_TAIL    = 200;
    localparam int DRAIN_CYCLES  = 12;
    localparam int PRINT_CAP     = 100;
    localparam int RUN_LIMIT_NS  = 5000000;

    // one directed row: input word, and an optional hand-typed result
    typedef struct packed {
        hsv_word_t px;
        logic      typed;
        rgb_word_t want;
    } stim_row_t;

    // hue, saturation, brightness, alpha -> red, green, blue, alpha
    localparam stim_row_t DIRECTED_ROWS [DIR_COUNT] = '{
        // black, gray and white, plus an all-ones word
        '{'{8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd0,   8'd0,   8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{8'd100, 8'd0,   8'd128, 8'd17 }, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd17 }},
        '{'{8'd200, 8'd255, 8'd0,   8'd200}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd200}},
        // pure hues at each sector edge
        '{'{8'd0,   8'd255, 8'd255, 8'd128}, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd128}},
        '{'{8'd43,  8'd255, 8'd255, 8'd64 }, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd64 }},
        '{'{8'd86,  8'd255, 8'd255, 8'd32 }, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd32 }},
        '{'{8'd129, 8'd255, 8'd255, 8'd16 }, 1'b1, '{8'd0,   8'd255, 8'd255, 8'd16 }},
        '{'{8'd172, 8'd255, 8'd255, 8'd8  }, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd8  }},
        '{'{8'd215, 8'd255, 8'd255, 8'd4  }, 1'b1, '{8'd255, 8'd0,   8'd255, 8'd4  }},
        // just before and after edges, and the short last sector
        '{'{8'd42,  8'd255, 8'd255, 8'd2  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd85,  8'd255, 8'd255, 8'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd214, 8'd255, 8'd255, 8'd3  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd216, 8'd255, 8'd255, 8'd5  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd255, 8'd128, 8'd200, 8'd6  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        // mid-sector ramps at mixed levels
        '{'{8'd21,  8'd255, 8'd255, 8'd7  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd64,  8'd170, 8'd90,  8'd9  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd107, 8'd1,   8'd254, 8'd10 }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd150, 8'd254, 8'd1,   8'd11 }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd193, 8'd200, 8'd255, 8'd12 }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd240, 8'd85,  8'd170, 8'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }},
        '{'{8'd170, 8'd255, 8'd255, 8'd254}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'd0  }}
    };

    logic      clk;
    logic      rst_n;
    logic      hsv_valid;
    logic      hsv_stall;
    hsv_word_t hsv;
    logic      rgb_valid;
    logic      rgb_stall;
    rgb_word_t rgb;

    rgb_word_t rgb_expected [$];
    int        mismatch_count;
    bit        idling_on;

    hsv_to_rgb_8bit_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // rgb level prediction from exact truncated rationals
    function automatic rgb_word_t predict_pixel(input hsv_word_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned ramp_pos;
        int unsigned ramp_dist;
        int unsigned top_lvl;
        int unsigned floor_lvl;
        int unsigned ramp_lvl;
        sector_t     sec;
        rgb_word_t   res;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        top_lvl   = v;
        floor_lvl = (v * (FULL_SCALE - s)) / FULL_SCALE;
        ramp_pos  = h % (2 * SECTOR_STEPS);
        ramp_dist = (ramp_pos >= SECTOR_STEPS) ? ramp_pos - SECTOR_STEPS
                                               : SECTOR_STEPS - ramp_pos;
        ramp_lvl  = (v * (MID_DENOM - s * ramp_dist)) / MID_DENOM;
        sec = sector_t'(h / SECTOR_STEPS);
        case (sec)
            SEC_RED_YEL: res = '{8'(top_lvl),   8'(ramp_lvl),  8'(floor_lvl), px.alpha_in};
            SEC_YEL_GRN: res = '{8'(ramp_lvl),  8'(top_lvl),   8'(floor_lvl), px.alpha_in};
            SEC_GRN_CYN: res = '{8'(floor_lvl), 8'(top_lvl),   8'(ramp_lvl),  px.alpha_in};
            SEC_CYN_BLU: res = '{8'(floor_lvl), 8'(ramp_lvl),  8'(top_lvl),   px.alpha_in};
            SEC_BLU_MAG: res = '{8'(ramp_lvl),  8'(floor_lvl), 8'(top_lvl),   px.alpha_in};
            default:     res = '{8'(top_lvl),   8'(floor_lvl), 8'(ramp_lvl),  px.alpha_in};
        endcase
        return res;
    endfunction

    // random pixel, biased toward sector edges and level extremes
    function automatic hsv_word_t random_pixel();
        hsv_word_t px;
        px = hsv_word_t'($urandom);
        case ($urandom_range(0, 9))
            6: px.hue = 8'(43 * $urandom_range(0, 5) + 255 + $urandom_range(0, 2));
            7: px.saturation = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            8: px.brightness = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            9:
            begin
                px.saturation = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.brightness = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.alpha_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return px;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    // drive one input word, with an optional gap before it
    task automatic send_word(input hsv_word_t px, input bit typed, input rgb_word_t want);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            hsv_valid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clk);
        end
        @(negedge clk);
        hsv_valid <= 1'b1;
        hsv       <= px;
        @(posedge clk);
        while (hsv_stall) @(posedge clk);
        rgb_expected.push_back(typed ? want : predict_pixel(px));
    endtask

    // receiver stall bursts
    initial
    begin
        rgb_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                rgb_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            rgb_stall <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
    end

    // output word check against the oldest expectation
    always @(posedge clk)
    begin
        rgb_word_t want;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (rgb_expected.size() == 0)
                report_mismatch($sformatf("unexpected rgb word %h", rgb));
            else
            begin
                want = rgb_expected.pop_front();
                check_field("red",       rgb.red,       want.red);
                check_field("green",     rgb.green,     want.green);
                check_field("blue",      rgb.blue,      want.blue);
                check_field("alpha_out", rgb.alpha_out, want.alpha_out);
            end
        end
    end

    // reset, directed rows, random words, drain
    initial
    begin
        hsv_valid      = 1'b0;
        hsv            = '0;
        mismatch_count = 0;
        idling_on      = 1'b1;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_COUNT; i++)
            send_word(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            // no idling in the last stretch
            if (n == RANDOM_COUNT - QUIET_TAIL)
                idling_on = 1'b0;
            send_word(random_pixel(), 1'b0, '0);
        end
        @(negedge clk);
        hsv_valid <= 1'b0;

        while (rgb_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
